/* design/byte_budget_lru_cache_core_macros.svh */
// Assertion helpers for the cache directory.
`ifndef BYTE_BUDGET_LRU_CACHE_CORE_MACROS_SVH
`define BYTE_BUDGET_LRU_CACHE_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define BBLC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication.
`define BBLC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`else

`define BBLC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BBLC_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* design/bblc_pkg.sv */
package bblc_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int OFFSET_BITS = 40;
    localparam int SIZE_BITS   = 24;
    localparam int LIMIT_BITS  = 32;
    localparam int FSZ_BITS    = 40;
    localparam int CFG_BITS    = 40;
    localparam int STAT_BITS   = 32;

    // configuration register indexes
    typedef enum logic [0:0] {
        REG_CACHE_LIMIT = 1'b0,
        REG_FILE_SIZE   = 1'b1
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_HIT   = 2'd0,
        ST_MISS  = 2'd1,
        ST_OOR   = 2'd2,
        ST_CLEAR = 2'd3
    } t_status;

    typedef enum logic [0:0] {
        KIND_FETCH = 1'b0,
        KIND_CLEAR = 1'b1
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_DECIDE,
        S_EV_CHK,
        S_EV_SCAN,
        S_INSERT,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic [0:0]             kind;
        logic [OFFSET_BITS-1:0] request_offset;
        logic [SIZE_BITS-1:0]   request_size;
    } t_req;

    typedef struct packed {
        t_status              status;
        logic [3:0]           entry_slot;
        logic [4:0]           evicted_now;
        logic [STAT_BITS-1:0] cached_bytes;
        logic [4:0]           entries_in_use;
        logic [STAT_BITS-1:0] fetch_count;
        logic [STAT_BITS-1:0] hit_count;
        logic [STAT_BITS-1:0] miss_count;
        logic [STAT_BITS-1:0] bytes_from_file;
        logic [STAT_BITS-1:0] eviction_count;
    } t_rsp;

endpackage

/* design/byte_budget_lru_cache_core.sv */
// Channel | Dir | Handshake                  | Payload
// in      | in  | i_in_valid / o_in_ready    | i_in_data  (bblc_pkg::t_req)
// out     | out | o_out_valid / i_out_ready  | o_out_data (bblc_pkg::t_rsp)
// cfg     | in  | i_cfg_we (no wait)         | i_cfg_idx, i_cfg_data
//
// Steps: clear and out-of-range go from S_CHECK straight to S_FINISH; a hit or a
//   resize scans every slot in S_SCAN, then passes S_DECIDE; a fresh insert also
//   passes S_EV_CHK and S_INSERT, with an S_EV_SCAN walk per eviction. The single
//   key/age compare walks one slot a cycle.
// Reset: i_rst_n synchronous, active low; clears valid bits, totals and counters.
// Stalls: one item at a time; a finished result waits in the output register
//   and the sequencer holds in its last step until that register frees up.
module byte_budget_lru_cache_core (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  bblc_pkg::t_req           i_in_data,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output bblc_pkg::t_rsp           o_out_data,
    input  logic                     i_cfg_we,
    input  bblc_pkg::t_reg_idx       i_cfg_idx,
    input  logic [bblc_pkg::CFG_BITS-1:0] i_cfg_data
);
    import bblc_pkg::*;

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);
    // exact byte sum over all slots
    localparam int SW = SIZE_BITS + CW;
    localparam logic [IW-1:0] LAST_IDX = IW'(MAX_ENTRIES - 1);

    function automatic logic [STAT_BITS-1:0] sat_add(input logic [STAT_BITS-1:0] a,
                                                     input logic [STAT_BITS-1:0] b);
        logic [STAT_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[STAT_BITS] ? '1 : s[STAT_BITS-1:0];
    endfunction

    // config
    logic [LIMIT_BITS-1:0] r_limit;
    logic [FSZ_BITS-1:0]   r_fsz;

    // directory
    logic [MAX_ENTRIES-1:0] r_valid;
    logic [OFFSET_BITS-1:0] r_key [MAX_ENTRIES];
    logic [SIZE_BITS-1:0]   r_len [MAX_ENTRIES];
    logic [IW-1:0]          r_age [MAX_ENTRIES];
    logic [CW-1:0]          r_count;
    logic [SW-1:0]          r_sum;

    // stats
    logic [STAT_BITS-1:0] r_fetch, r_hit, r_miss, r_bytes, r_evict;

    // current request and working registers
    t_state               r_state, n_state;
    logic                 r_kind;
    logic [OFFSET_BITS-1:0] r_off;
    logic [SIZE_BITS-1:0] r_size;
    logic [IW-1:0]        r_idx;
    logic                 r_found_v;
    logic [IW-1:0]        r_found;
    logic [SIZE_BITS-1:0] r_found_len;
    t_status              r_status;
    logic [IW-1:0]        r_slot;
    logic [CW-1:0]        r_evicted;

    t_rsp                 r_out;
    logic                 r_out_valid;

    // combinational helpers
    logic                 w_in_xfer;
    logic                 w_out_free;
    logic                 w_oor;
    logic                 w_match;
    logic                 w_is_hit;
    logic                 w_need_evict;
    logic                 w_oldest;
    logic [IW-1:0]        w_free;
    logic [63:0]          w_sum64;
    logic [STAT_BITS-1:0] w_cached;

    assign w_in_xfer  = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    // bounds check without wrap
    assign w_oor = ({1'b0, r_off} + (OFFSET_BITS + 1)'(r_size)) >
                   (OFFSET_BITS + 1)'(r_fsz);

    assign w_match  = r_valid[r_idx] && (r_key[r_idx] == r_off);
    assign w_is_hit = r_found_v && (r_found_len >= r_size);

    // table not empty, and either full or budget set and the new entry would overflow it
    assign w_need_evict = (r_count != '0) &&
        ((r_count >= CW'(MAX_ENTRIES)) ||
         ((r_limit != '0) && ((64'(r_sum) + 64'(r_size)) > 64'(r_limit))));

    // ages of valid slots are always 0..count-1, so the oldest is count-1
    assign w_oldest = r_valid[r_idx] && (CW'(r_age[r_idx]) == (r_count - CW'(1)));

    // lowest numbered free slot
    always_comb begin
        w_free = '0;
        for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                w_free = IW'(i);
            end
        end
    end

    assign w_sum64  = 64'(r_sum);
    assign w_cached = (w_sum64 > 64'(32'hFFFF_FFFF)) ? '1 : w_sum64[STAT_BITS-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) n_state = S_CHECK;
            end
            S_CHECK: begin
                if (r_kind == KIND_CLEAR || w_oor) n_state = S_FINISH;
                else                               n_state = S_SCAN;
            end
            S_SCAN: begin
                if (r_idx == LAST_IDX) n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (r_found_v) n_state = S_FINISH;
                else           n_state = S_EV_CHK;
            end
            S_EV_CHK: begin
                if (w_need_evict) n_state = S_EV_SCAN;
                else              n_state = S_INSERT;
            end
            S_EV_SCAN: begin
                if (w_oldest || r_idx == LAST_IDX) n_state = S_EV_CHK;
            end
            S_INSERT: n_state = S_FINISH;
            S_FINISH: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready  = (r_state == S_IDLE);
        o_out_valid = r_out_valid;
        o_out_data  = r_out;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_limit     <= '0;
            r_fsz       <= '0;
            r_valid     <= '0;
            r_count     <= '0;
            r_sum       <= '0;
            r_fetch     <= '0;
            r_hit       <= '0;
            r_miss      <= '0;
            r_bytes     <= '0;
            r_evict     <= '0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_CACHE_LIMIT: r_limit <= i_cfg_data[LIMIT_BITS-1:0];
                    REG_FILE_SIZE:   r_fsz   <= i_cfg_data[FSZ_BITS-1:0];
                    default: ;
                endcase
            end

            // a new result loads as the old one leaves
            if (r_state == S_FINISH && w_out_free) r_out_valid <= 1'b1;
            else if (r_out_valid && i_out_ready)   r_out_valid <= 1'b0;

            case (r_state)
                S_CHECK: begin
                    if (r_kind == KIND_CLEAR) begin
                        r_valid <= '0;
                        r_count <= '0;
                        r_sum   <= '0;
                    end else begin
                        r_fetch <= sat_add(r_fetch, STAT_BITS'(1));
                    end
                end
                S_DECIDE: begin
                    if (w_is_hit) begin
                        r_hit <= sat_add(r_hit, STAT_BITS'(1));
                    end else begin
                        r_miss  <= sat_add(r_miss, STAT_BITS'(1));
                        r_bytes <= sat_add(r_bytes, STAT_BITS'(r_size));
                        // resize keeps the exact sum in step
                        if (r_found_v) r_sum <= r_sum - SW'(r_found_len) + SW'(r_size);
                    end
                end
                S_EV_SCAN: begin
                    if (w_oldest) begin
                        r_valid[r_idx] <= 1'b0;
                        r_count        <= r_count - CW'(1);
                        r_sum          <= r_sum - SW'(r_len[r_idx]);
                        r_evict        <= sat_add(r_evict, STAT_BITS'(1));
                    end
                end
                S_INSERT: begin
                    r_valid[w_free] <= 1'b1;
                    r_count         <= r_count + CW'(1);
                    r_sum           <= r_sum + SW'(r_size);
                end
                default: ;
            endcase
        end
    end

    // payload and working registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    r_kind <= i_in_data.kind;
                    r_off  <= i_in_data.request_offset;
                    r_size <= i_in_data.request_size;
                end
            end
            S_CHECK: begin
                r_idx     <= '0;
                r_found_v <= 1'b0;
                r_slot    <= '0;
                r_evicted <= '0;
                if (r_kind == KIND_CLEAR) r_status <= ST_CLEAR;
                else if (w_oor)           r_status <= ST_OOR;
            end
            S_SCAN: begin
                // last match wins
                if (w_match) begin
                    r_found_v   <= 1'b1;
                    r_found     <= r_idx;
                    r_found_len <= r_len[r_idx];
                end
                r_idx <= r_idx + IW'(1);
            end
            S_DECIDE: begin
                if (r_found_v) begin
                    r_slot <= r_found;
                    if (!w_is_hit) r_len[r_found] <= r_size;
                    // move to MRU; younger entries age by one
                    for (int i = 0; i < MAX_ENTRIES; i++) begin
                        if (r_valid[i] && IW'(i) != r_found && r_age[i] < r_age[r_found]) begin
                            r_age[i] <= r_age[i] + IW'(1);
                        end
                    end
                    r_age[r_found] <= '0;
                end
                r_status <= w_is_hit ? ST_HIT : ST_MISS;
            end
            S_EV_CHK: begin
                r_idx <= '0;
            end
            S_EV_SCAN: begin
                if (w_oldest) r_evicted <= r_evicted + CW'(1);
                r_idx <= r_idx + IW'(1);
            end
            S_INSERT: begin
                for (int i = 0; i < MAX_ENTRIES; i++) begin
                    if (r_valid[i]) r_age[i] <= r_age[i] + IW'(1);
                end
                r_key[w_free] <= r_off;
                r_len[w_free] <= r_size;
                r_age[w_free] <= '0;
                r_slot        <= w_free;
            end
            S_FINISH: begin
                if (w_out_free) begin
                    r_out.status          <= r_status;
                    r_out.entry_slot      <= 4'(r_slot);
                    r_out.evicted_now     <= 5'(r_evicted);
                    r_out.cached_bytes    <= w_cached;
                    r_out.entries_in_use  <= 5'(r_count);
                    r_out.fetch_count     <= r_fetch;
                    r_out.hit_count       <= r_hit;
                    r_out.miss_count      <= r_miss;
                    r_out.bytes_from_file <= r_bytes;
                    r_out.eviction_count  <= r_evict;
                end
            end
            default: ;
        endcase
    end

`include "byte_budget_lru_cache_core_macros.svh"

    `BBLC_ASSERT_IMP(a_count_tracks_valid, i_clk, i_rst_n, 1'b1, r_count == CW'($countones(r_valid)))
    `BBLC_ASSERT_IMP(a_count_in_range, i_clk, i_rst_n, 1'b1, r_count <= CW'(MAX_ENTRIES))
    `BBLC_ASSERT_IMP(a_evict_nonempty, i_clk, i_rst_n, r_state == S_EV_SCAN, r_count != '0)
    `BBLC_ASSERT_NXT(a_insert_has_room, i_clk, i_rst_n, r_state == S_INSERT, r_count != '0)
    `BBLC_ASSERT_NXT(a_accept_to_check, i_clk, i_rst_n, w_in_xfer, r_state == S_CHECK)

endmodule
